>>> hdl/rrss_pkg.sv
package rrss_pkg;

    localparam int MAX_RUNS = 4096;
    localparam int POS_BITS = 30;
    localparam int IDX_W    = $clog2(MAX_RUNS);
    localparam int CNT_W    = IDX_W + 1;
    localparam int SUM_W    = 59;
    localparam int WORD_W   = 2 * POS_BITS;
    localparam int PROD_W   = 2 * (POS_BITS + 1);

    localparam logic [POS_BITS-1:0] RESET_SIZE = POS_BITS'(1024);

    typedef logic [POS_BITS-1:0] pos_t;
    typedef logic [POS_BITS:0]   len_t;
    typedef logic [IDX_W-1:0]    idx_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [WORD_W-1:0]   word_t;

    typedef enum logic [1:0] {
        ACT_INIT   = 2'd0,
        ACT_INVERT = 2'd1,
        ACT_SUM    = 2'd2,
        ACT_NOP    = 2'd3
    } act_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } st_t;

    // datapath micro-operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_INIT,
        OP_CHECK,
        OP_SCAN_RD,
        OP_NEED_EV,
        OP_CAP,
        OP_SPL_EV,
        OP_SH_RD,
        OP_SH_WR,
        OP_SPW1,
        OP_SPW2,
        OP_NEXTCUT,
        OP_FINDINIT,
        OP_FIND_EV,
        OP_SW_RDA,
        OP_SW_RDB,
        OP_SW_WA,
        OP_SW_WB,
        OP_SG_RD,
        OP_SG_WR,
        OP_EMIT
    } op_t;

    typedef struct packed {
        logic is_init;
        logic is_nop;
        logic is_sum;
        logic bad;
        logic full;
        logic hit;
        logic last;
        logic sh_done;
        logic sw_lt;
        logic sw_eq;
        logic out_free;
    } dp_stat_t;

endpackage

>>> hdl/rrss_dp.sv
module rrss_dp import rrss_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  op_t                 op,
    output dp_stat_t            stat,
    input  logic [1:0]          action,
    input  logic [POS_BITS-1:0] first_pos,
    input  logic [POS_BITS-1:0] last_pos,
    input  logic                cfg_we,
    input  logic [POS_BITS-1:0] cfg_data,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [SUM_W-1:0]    sum_value,
    output logic [1:0]          status
);

    word_t mem [MAX_RUNS];

    pos_t              mem_size_reg, mem_size_next;
    pos_t              total_reg, total_next;
    cnt_t              count_reg, count_next;
    act_t              act_reg, act_next;
    pos_t              x_reg, x_next;
    pos_t              y_reg, y_next;
    pos_t              k_reg, k_next;
    pos_t              s_reg, s_next;
    pos_t              e_reg, e_next;
    pos_t              off_reg, off_next;
    len_t              pos_reg, pos_next;
    logic [1:0]        need_reg, need_next;
    idx_t              idx_reg, idx_next;
    idx_t              r_reg, r_next;
    idx_t              a_reg, a_next;
    idx_t              b_reg, b_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic              prod_vld_reg, prod_vld_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    st_t               res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    logic [SUM_W-1:0]  sum_out_reg, sum_out_next;
    st_t               st_out_reg, st_out_next;
    logic              e0_wr_reg, e0_wr_next;
    word_t             rd_word_reg;
    logic              rd_dflt_reg;

    logic  rd_en, wr_en;
    idx_t  rd_addr, wr_addr;
    word_t wr_data, rd_word;
    pos_t  rd_s, rd_e, lo, hi, new_end, new_start;
    len_t  sz, pos_end, xm1, yl, kl, sum_se, mul_a, mul_b;
    logic  in_x, in_y, in_k, asc;
    logic [PROD_W-1:0] prod_c;

    // Entry 0 reads as the reset run until it is first written
    assign rd_word = rd_dflt_reg ? {pos_t'(1), RESET_SIZE} : rd_word_reg;
    assign rd_s    = rd_word[WORD_W-1:POS_BITS];
    assign rd_e    = rd_word[POS_BITS-1:0];

    assign sz      = (rd_s <= rd_e) ? len_t'({1'b0, rd_e} - {1'b0, rd_s} + len_t'(1))
                                    : len_t'({1'b0, rd_s} - {1'b0, rd_e} + len_t'(1));
    assign pos_end = pos_reg + sz;
    assign xm1     = {1'b0, x_reg} - len_t'(1);
    assign yl      = {1'b0, y_reg};
    assign kl      = {1'b0, k_reg};
    assign in_x    = (pos_reg < xm1) && (xm1 < pos_end);
    assign in_y    = (pos_reg < yl) && (yl < pos_end);
    assign in_k    = (pos_reg < kl) && (kl < pos_end);

    // (s+e)*len is even: halve whichever factor is even
    assign sum_se  = {1'b0, rd_s} + {1'b0, rd_e};
    assign mul_a   = sz[0] ? (sum_se >> 1) : sum_se;
    assign mul_b   = sz[0] ? sz : (sz >> 1);
    assign prod_c  = {{(PROD_W-POS_BITS-1){1'b0}}, mul_a} * {{(PROD_W-POS_BITS-1){1'b0}}, mul_b};

    assign asc       = s_reg <= e_reg;
    assign new_end   = asc ? pos_t'(s_reg + off_reg - pos_t'(1))
                           : pos_t'(s_reg - off_reg + pos_t'(1));
    assign new_start = asc ? pos_t'(s_reg + off_reg) : pos_t'(s_reg - off_reg);

    assign lo = (first_pos > last_pos) ? last_pos : first_pos;
    assign hi = (first_pos > last_pos) ? first_pos : last_pos;

    always_comb
    begin
        stat.is_init  = act_reg == ACT_INIT;
        stat.is_nop   = act_reg == ACT_NOP;
        stat.is_sum   = act_reg == ACT_SUM;
        stat.bad      = (x_reg == '0) || (y_reg > total_reg);
        stat.full     = ({1'b0, count_reg} + (CNT_W+1)'(need_reg)) > (CNT_W+1)'(MAX_RUNS);
        stat.hit      = in_k;
        stat.last     = ({1'b0, idx_reg} + cnt_t'(1)) == count_reg;
        stat.sh_done  = idx_reg == r_reg;
        stat.sw_lt    = a_reg < b_reg;
        stat.sw_eq    = a_reg == b_reg;
        stat.out_free = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        mem_size_next  = cfg_we ? cfg_data : mem_size_reg;
        total_next     = total_reg;
        count_next     = count_reg;
        act_next       = act_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        k_next         = k_reg;
        s_next         = s_reg;
        e_next         = e_reg;
        off_next       = off_reg;
        pos_next       = pos_reg;
        need_next      = need_reg;
        idx_next       = idx_reg;
        r_next         = r_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        prod_next      = prod_reg;
        prod_vld_next  = 1'b0;
        sum_next       = prod_vld_reg ? SUM_W'(sum_reg + prod_reg[SUM_W-1:0]) : sum_reg;
        res_next       = res_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        sum_out_next   = sum_out_reg;
        st_out_next    = st_out_reg;
        rd_en          = 1'b0;
        rd_addr        = idx_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = rd_word;

        case (op)
            OP_LOAD:
            begin
                act_next = act_t'(action);
                x_next   = lo;
                y_next   = hi;
                sum_next = '0;
                res_next = ST_OK;
            end
            OP_INIT:
            begin
                total_next = mem_size_reg;
                if (mem_size_reg == '0)
                begin
                    count_next = '0;
                end
                else
                begin
                    count_next = cnt_t'(1);
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                    wr_data    = {pos_t'(1), mem_size_reg};
                end
            end
            OP_CHECK:
            begin
                if (stat.bad)
                    res_next = ST_RANGE;
                idx_next  = '0;
                pos_next  = '0;
                need_next = '0;
            end
            OP_SCAN_RD:
            begin
                rd_en = 1'b1;
            end
            OP_NEED_EV:
            begin
                need_next = need_reg + {1'b0, in_x} + {1'b0, in_y};
                idx_next  = idx_reg + idx_t'(1);
                pos_next  = pos_end;
            end
            OP_CAP:
            begin
                if (stat.full)
                    res_next = ST_FULL;
                k_next   = xm1[POS_BITS-1:0];
                idx_next = '0;
                pos_next = '0;
            end
            OP_SPL_EV:
            begin
                if (in_k)
                begin
                    r_next   = idx_reg;
                    s_next   = rd_s;
                    e_next   = rd_e;
                    off_next = pos_t'(kl - pos_reg);
                    idx_next = idx_t'(count_reg - cnt_t'(1));
                end
                else
                begin
                    idx_next = idx_reg + idx_t'(1);
                    pos_next = pos_end;
                end
            end
            OP_SH_RD:
            begin
                rd_en = 1'b1;
            end
            OP_SH_WR:
            begin
                wr_en    = 1'b1;
                wr_addr  = idx_reg + idx_t'(1);
                idx_next = idx_reg - idx_t'(1);
            end
            OP_SPW1:
            begin
                wr_en   = 1'b1;
                wr_addr = r_reg;
                wr_data = {s_reg, new_end};
            end
            OP_SPW2:
            begin
                wr_en      = 1'b1;
                wr_addr    = r_reg + idx_t'(1);
                wr_data    = {new_start, e_reg};
                count_next = count_reg + cnt_t'(1);
            end
            OP_NEXTCUT:
            begin
                k_next   = y_reg;
                idx_next = '0;
                pos_next = '0;
            end
            OP_FINDINIT:
            begin
                idx_next = '0;
                pos_next = '0;
            end
            OP_FIND_EV:
            begin
                if (pos_reg == xm1)
                    a_next = idx_reg;
                if (pos_end == yl)
                    b_next = idx_reg;
                if (act_reg == ACT_SUM && pos_reg >= xm1 && pos_end <= yl)
                begin
                    prod_next     = prod_c;
                    prod_vld_next = 1'b1;
                end
                idx_next = idx_reg + idx_t'(1);
                pos_next = pos_end;
            end
            OP_SW_RDA:
            begin
                rd_en   = 1'b1;
                rd_addr = a_reg;
            end
            OP_SW_RDB:
            begin
                rd_en   = 1'b1;
                rd_addr = b_reg;
                s_next  = rd_s;
                e_next  = rd_e;
            end
            OP_SW_WA:
            begin
                wr_en   = 1'b1;
                wr_addr = a_reg;
                wr_data = {rd_e, rd_s};
            end
            OP_SW_WB:
            begin
                wr_en   = 1'b1;
                wr_addr = b_reg;
                wr_data = {e_reg, s_reg};
                a_next  = a_reg + idx_t'(1);
                b_next  = b_reg - idx_t'(1);
            end
            OP_SG_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = a_reg;
            end
            OP_SG_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = a_reg;
                wr_data = {rd_e, rd_s};
            end
            OP_EMIT:
            begin
                out_valid_next = 1'b1;
                sum_out_next   = (res_reg == ST_OK) ? sum_reg : '0;
                st_out_next    = res_reg;
            end
            default:
            begin
            end
        endcase

        e0_wr_next = e0_wr_reg || (wr_en && wr_addr == '0);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_word_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_size_reg  <= RESET_SIZE;
            total_reg     <= RESET_SIZE;
            count_reg     <= cnt_t'(1);
            act_reg       <= ACT_NOP;
            x_reg         <= '0;
            y_reg         <= '0;
            k_reg         <= '0;
            s_reg         <= '0;
            e_reg         <= '0;
            off_reg       <= '0;
            pos_reg       <= '0;
            need_reg      <= '0;
            idx_reg       <= '0;
            r_reg         <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            prod_reg      <= '0;
            prod_vld_reg  <= 1'b0;
            sum_reg       <= '0;
            res_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
            sum_out_reg   <= '0;
            st_out_reg    <= ST_OK;
            e0_wr_reg     <= 1'b0;
            rd_dflt_reg   <= 1'b0;
        end
        else
        begin
            mem_size_reg  <= mem_size_next;
            total_reg     <= total_next;
            count_reg     <= count_next;
            act_reg       <= act_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            k_reg         <= k_next;
            s_reg         <= s_next;
            e_reg         <= e_next;
            off_reg       <= off_next;
            pos_reg       <= pos_next;
            need_reg      <= need_next;
            idx_reg       <= idx_next;
            r_reg         <= r_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            prod_reg      <= prod_next;
            prod_vld_reg  <= prod_vld_next;
            sum_reg       <= sum_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
            sum_out_reg   <= sum_out_next;
            st_out_reg    <= st_out_next;
            e0_wr_reg     <= e0_wr_next;
            if (rd_en)
                rd_dflt_reg <= (rd_addr == '0) && !e0_wr_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign sum_value = sum_out_reg;
    assign status    = st_out_reg;

endmodule

>>> hdl/rrss_ctrl.sv
module rrss_ctrl import rrss_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output op_t      op
);

    typedef enum logic [25:0] {
        S_IDLE     = 26'd1 << 0,
        S_DISP     = 26'd1 << 1,
        S_INIT     = 26'd1 << 2,
        S_CHECK    = 26'd1 << 3,
        S_NEED_RD  = 26'd1 << 4,
        S_NEED_EV  = 26'd1 << 5,
        S_CAP      = 26'd1 << 6,
        S_SPL_RD   = 26'd1 << 7,
        S_SPL_EV   = 26'd1 << 8,
        S_SH_CHK   = 26'd1 << 9,
        S_SH_RD    = 26'd1 << 10,
        S_SH_WR    = 26'd1 << 11,
        S_SPW1     = 26'd1 << 12,
        S_SPW2     = 26'd1 << 13,
        S_SPL_DONE = 26'd1 << 14,
        S_FIND_RD  = 26'd1 << 15,
        S_FIND_EV  = 26'd1 << 16,
        S_FLUSH    = 26'd1 << 17,
        S_SW_CHK   = 26'd1 << 18,
        S_SW_RDA   = 26'd1 << 19,
        S_SW_RDB   = 26'd1 << 20,
        S_SW_WA    = 26'd1 << 21,
        S_SW_WB    = 26'd1 << 22,
        S_SG_RD    = 26'd1 << 23,
        S_SG_WR    = 26'd1 << 24,
        S_EMIT     = 26'd1 << 25
    } state_t;

    state_t state_reg, state_next;
    logic   second_reg, second_next;

    always_comb
    begin
        state_next  = state_reg;
        second_next = second_reg;
        op          = OP_NONE;
        in_ready    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op         = OP_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (stat.is_init)
                    state_next = S_INIT;
                else if (stat.is_nop)
                    state_next = S_EMIT;
                else
                    state_next = S_CHECK;
            end
            S_INIT:
            begin
                op         = OP_INIT;
                state_next = S_EMIT;
            end
            S_CHECK:
            begin
                op         = OP_CHECK;
                state_next = stat.bad ? S_EMIT : S_NEED_RD;
            end
            S_NEED_RD:
            begin
                op         = OP_SCAN_RD;
                state_next = S_NEED_EV;
            end
            S_NEED_EV:
            begin
                op         = OP_NEED_EV;
                state_next = stat.last ? S_CAP : S_NEED_RD;
            end
            S_CAP:
            begin
                op          = OP_CAP;
                second_next = 1'b0;
                state_next  = stat.full ? S_EMIT : S_SPL_RD;
            end
            S_SPL_RD:
            begin
                op         = OP_SCAN_RD;
                state_next = S_SPL_EV;
            end
            S_SPL_EV:
            begin
                op = OP_SPL_EV;
                if (stat.hit)
                    state_next = S_SH_CHK;
                else if (stat.last)
                    state_next = S_SPL_DONE;
                else
                    state_next = S_SPL_RD;
            end
            S_SH_CHK:
            begin
                state_next = stat.sh_done ? S_SPW1 : S_SH_RD;
            end
            S_SH_RD:
            begin
                op         = OP_SH_RD;
                state_next = S_SH_WR;
            end
            S_SH_WR:
            begin
                op         = OP_SH_WR;
                state_next = S_SH_CHK;
            end
            S_SPW1:
            begin
                op         = OP_SPW1;
                state_next = S_SPW2;
            end
            S_SPW2:
            begin
                op         = OP_SPW2;
                state_next = S_SPL_DONE;
            end
            S_SPL_DONE:
            begin
                if (!second_reg)
                begin
                    op          = OP_NEXTCUT;
                    second_next = 1'b1;
                    state_next  = S_SPL_RD;
                end
                else
                begin
                    op         = OP_FINDINIT;
                    state_next = S_FIND_RD;
                end
            end
            S_FIND_RD:
            begin
                op         = OP_SCAN_RD;
                state_next = S_FIND_EV;
            end
            S_FIND_EV:
            begin
                op = OP_FIND_EV;
                if (!stat.last)
                    state_next = S_FIND_RD;
                else
                    state_next = stat.is_sum ? S_FLUSH : S_SW_CHK;
            end
            S_FLUSH:
            begin
                state_next = S_EMIT;
            end
            S_SW_CHK:
            begin
                if (stat.sw_lt)
                    state_next = S_SW_RDA;
                else if (stat.sw_eq)
                    state_next = S_SG_RD;
                else
                    state_next = S_EMIT;
            end
            S_SW_RDA:
            begin
                op         = OP_SW_RDA;
                state_next = S_SW_RDB;
            end
            S_SW_RDB:
            begin
                op         = OP_SW_RDB;
                state_next = S_SW_WA;
            end
            S_SW_WA:
            begin
                op         = OP_SW_WA;
                state_next = S_SW_WB;
            end
            S_SW_WB:
            begin
                op         = OP_SW_WB;
                state_next = S_SW_CHK;
            end
            S_SG_RD:
            begin
                op         = OP_SG_RD;
                state_next = S_SG_WR;
            end
            S_SG_WR:
            begin
                op         = OP_SG_WR;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    op         = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            second_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            second_reg <= second_next;
        end
    end

endmodule

>>> hdl/range_reverse_sum_segments.sv
// Channel   Handshake            Payload
// in        in_valid/in_ready    action, first_pos, last_pos
// out       out_valid/out_ready  sum_value, status
// cfg       cfg_valid/cfg_ready  cfg_data (mem_size)
//
// One transaction at a time. Invert and sum make four scans of the run table and
// move runs up one entry each time a split opens a slot; invert then swaps pairs
// of runs, reversing each run as it goes.
// Reset (rst_n, asynchronous) gives one run 1..1024 at once; no clearing pass.
// A finished result waits in the output register while the next input
// transaction is taken; the controller stalls only when that register is full.
module range_reverse_sum_segments import rrss_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          action,
    input  logic [POS_BITS-1:0] first_pos,
    input  logic [POS_BITS-1:0] last_pos,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [SUM_W-1:0]    sum_value,
    output logic [1:0]          status,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [POS_BITS-1:0] cfg_data
);

    op_t      op;
    dp_stat_t stat;

    // Configuration is to be written only while idle; the user is bound to this, so always take it
    assign cfg_ready = 1'b1;

    // Sequence the scan, split, shift and swap steps
    rrss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .op       (op)
    );

    // Hold the run table, the position accumulator and the result register
    rrss_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .stat      (stat),
        .action    (action),
        .first_pos (first_pos),
        .last_pos  (last_pos),
        .cfg_we    (cfg_valid),
        .cfg_data  (cfg_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .sum_value (sum_value),
        .status    (status)
    );

endmodule

>>> hdl/rrss_chk.sv
module rrss_chk import rrss_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic [1:0]          action,
    input logic [POS_BITS-1:0] first_pos,
    input logic [POS_BITS-1:0] last_pos,
    input logic                out_valid,
    input logic                out_ready,
    input logic [SUM_W-1:0]    sum_value,
    input logic [1:0]          status
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sum_value) && $stable(status))
        else $error("result changed while stalled");

    // Hold a waiting input transaction
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(action) && $stable(first_pos)
            && $stable(last_pos))
        else $error("input changed while waiting");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3)
        else $error("undefined status code");

    // Drop the sum on any failed transaction
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> sum_value == '0)
        else $error("nonzero sum with error status");

    // One transaction in flight
    a_one_at_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transaction taken while busy");

endmodule

bind range_reverse_sum_segments rrss_chk u_rrss_chk (.*);

>>> tb/tb_top.sv
module tb_top import rrss_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    // One input transaction: an action and two positions, in either order.
    typedef struct {
        act_t action;
        pos_t first_pos;
        pos_t last_pos;
    } cmd_t;

    // One output transaction as predicted.
    typedef struct {
        logic [SUM_W-1:0] sum_value;
        st_t              status;
    } res_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [1:0]          action;
    logic [POS_BITS-1:0] first_pos;
    logic [POS_BITS-1:0] last_pos;
    logic                out_valid;
    logic                out_ready;
    logic [SUM_W-1:0]    sum_value;
    logic [1:0]          status;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [POS_BITS-1:0] cfg_data;

    range_reverse_sum_segments i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .first_pos (first_pos),
        .last_pos  (last_pos),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sum_value (sum_value),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Mirror of the run table and of the size register.
    pos_t            run_lo [MAX_RUNS];
    pos_t            run_hi [MAX_RUNS];
    int unsigned     run_total;
    longint unsigned size_reg;

    cmd_t cmd_q [$];   // transactions waiting for the driver
    res_t result_q [$];   // predicted results, oldest first

    int  n_errors;
    int  n_checked;
    int  n_sums;
    bit  in_acc;

    // Burst/gap state of the sender, and the receiver stall pattern.
    int  burst_left;
    int  gap_left;
    int  stall_mode;
    int  stall_cnt;

    function automatic longint unsigned seg_len(int unsigned i);
        longint unsigned lo;
        longint unsigned hi;
        lo = run_lo[i];
        hi = run_hi[i];
        return (lo <= hi) ? hi - lo + 1 : lo - hi + 1;
    endfunction

    function automatic longint unsigned table_len();
        longint unsigned t;
        t = 0;
        for (int unsigned i = 0; i < run_total; i++)
            t += seg_len(i);
        return t;
    endfunction

    // Index of the run cut strictly inside by a boundary after position k, or -1.
    function automatic int find_cut(longint unsigned k, output longint unsigned off);
        longint unsigned p;
        longint unsigned sz;
        p = 0;
        off = 0;
        for (int unsigned i = 0; i < run_total; i++)
        begin
            sz = seg_len(i);
            if (p + sz > k)
            begin
                if (p == k)
                    return -1;
                off = k - p;
                return int'(i);
            end
            p += sz;
        end
        return -1;
    endfunction

    function automatic void split_at(longint unsigned k);
        longint unsigned off;
        int              r;
        pos_t            s;
        r = find_cut(k, off);
        if (r < 0 || run_total >= MAX_RUNS)
            return;
        for (int i = int'(run_total); i > r; i--)
        begin
            run_lo[i] = run_lo[i-1];
            run_hi[i] = run_hi[i-1];
        end
        run_total++;
        s = run_lo[r];
        if (s <= run_hi[r])
        begin
            run_hi[r]   = pos_t'(s + off - 1);
            run_lo[r+1] = pos_t'(s + off);
        end
        else
        begin
            run_hi[r]   = pos_t'(s - off + 1);
            run_lo[r+1] = pos_t'(s - off);
        end
    endfunction

    // Apply one transaction to the mirror and return the result it must produce.
    function automatic res_t apply_range_op(cmd_t c);
        res_t            r;
        longint unsigned x;
        longint unsigned y;
        longint unsigned off;
        longint unsigned p;
        longint unsigned sz;
        longint unsigned acc;
        int              need;
        int              ia;
        int              ib;
        pos_t            t;
        r.sum_value = '0;
        r.status    = ST_OK;
        if (c.action == ACT_INIT)
        begin
            if (size_reg == 0)
                run_total = 0;
            else
            begin
                run_lo[0] = pos_t'(1);
                run_hi[0] = pos_t'(size_reg);
                run_total = 1;
            end
            return r;
        end
        if (c.action == ACT_NOP)
            return r;
        x = c.first_pos;
        y = c.last_pos;
        if (x > y)
        begin
            p = x;
            x = y;
            y = p;
        end
        if (x == 0 || y > table_len())
        begin
            r.status = ST_RANGE;
            return r;
        end
        need = 0;
        if (find_cut(x - 1, off) >= 0)
            need++;
        if (find_cut(y, off) >= 0)
            need++;
        if (run_total + need > MAX_RUNS)
        begin
            r.status = ST_FULL;
            return r;
        end
        split_at(x - 1);
        split_at(y);
        ia = -1;
        ib = -1;
        p  = 0;
        for (int unsigned i = 0; i < run_total; i++)
        begin
            sz = seg_len(i);
            if (p == x - 1)
                ia = int'(i);
            if (p + sz == y)
                ib = int'(i);
            p += sz;
        end
        if (ia < 0 || ib < ia)
            return r;
        if (c.action == ACT_INVERT)
        begin
            while (ia < ib)
            begin
                t = run_lo[ia];
                run_lo[ia] = run_hi[ib];
                run_hi[ib] = t;
                t = run_hi[ia];
                run_hi[ia] = run_lo[ib];
                run_lo[ib] = t;
                ia++;
                ib--;
            end
            if (ia == ib)
            begin
                t = run_lo[ia];
                run_lo[ia] = run_hi[ia];
                run_hi[ia] = t;
            end
        end
        else
        begin
            acc = 0;
            for (int i = ia; i <= ib; i++)
                acc += ((longint'(run_lo[i]) + run_hi[i]) * seg_len(i)) / 2;
            r.sum_value = acc[SUM_W-1:0];
        end
        return r;
    endfunction

    function automatic void push_cmd(act_t a, longint unsigned f, longint unsigned l);
        cmd_t c;
        c.action    = a;
        c.first_pos = pos_t'(f);
        c.last_pos  = pos_t'(l);
        cmd_q.insert(cmd_q.size(), c);
    endfunction

    // Random position mostly inside the current sequence, sometimes at or past its edges.
    function automatic longint unsigned pick_pos(longint unsigned len);
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return 0;
        if (sel == 1)
            return len + 1;
        if (sel == 2)
            return {$urandom} & 32'h3FFF_FFFF;
        if (len == 0)
            return 1;
        if (sel == 3)
            return len;
        return $urandom_range(1, int'(len));
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: the slowest run is far below this.
    initial
    begin
        #20_000_000;
        $display("FAIL range_reverse_sum_segments");
        $finish;
    end

    // Note each input handshake at the rising edge where it happens.
    always @(posedge clk)
    begin
        in_acc <= rst_n && in_valid && in_ready;
    end

    // Driver: pop one pending transaction at a time, sent in bursts with gaps.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (in_valid && !in_acc)
        begin
            // hold the transaction until it is taken
        end
        else
        begin
            if (in_acc)
            begin
                // the transaction was accepted at the last rising edge
                result_q.insert(result_q.size(), apply_range_op(cmd_q.pop_front()));
            end
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (cmd_q.size() > 0)
            begin
                in_valid  <= 1'b1;
                action    <= cmd_q[0].action;
                first_pos <= cmd_q[0].first_pos;
                last_pos  <= cmd_q[0].last_pos;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 6);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern: phases of always-ready, random and long stalls.
    always @(negedge clk)
    begin
        if (stall_cnt == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_cnt  = $urandom_range(20, 200);
        end
        stall_cnt--;
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Monitor: compare each output transaction against the oldest prediction.
    always @(posedge clk)
    begin
        res_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (result_q.size() == 0)
            begin
                $display("%0t: unexpected result sum_value=%0d status=%0d",
                         $time, sum_value, status);
                n_errors++;
            end
            else
            begin
                e = result_q.pop_front();
                n_checked++;
                if (sum_value !== e.sum_value)
                begin
                    $display("%0t: sum_value expected %0d actual %0d",
                             $time, e.sum_value, sum_value);
                    n_errors++;
                end
                if (status !== e.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, e.status, status);
                    n_errors++;
                end
            end
        end
    end

    // Wait until every queued transaction is in and answered.
    task automatic drain();
        while (cmd_q.size() > 0 || in_valid || result_q.size() > 0)
            @(negedge clk);
    endtask

    // Write mem_size while the block is idle.
    task automatic write_size(longint unsigned v);
        drain();
        repeat (8) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= pos_t'(v);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        size_reg = v & 32'h3FFF_FFFF;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random phase: mostly invert and sum inside the sequence, a few inits and no-ops.
    task automatic random_phase(int count);
        longint unsigned len;
        int              sel;
        for (int k = 0; k < count; k++)
        begin
            drain();
            len = table_len();
            sel = $urandom_range(0, 19);
            if (sel == 0)
                push_cmd(ACT_INIT, {$urandom} & 32'h3FFF_FFFF, {$urandom} & 32'h3FFF_FFFF);
            else if (sel == 1)
                push_cmd(ACT_NOP, {$urandom} & 32'h3FFF_FFFF, {$urandom} & 32'h3FFF_FFFF);
            else if (sel < 11)
                push_cmd(ACT_INVERT, pick_pos(len), pick_pos(len));
            else
                push_cmd(ACT_SUM, pick_pos(len), pick_pos(len));
            if (cmd_q[$].action == ACT_SUM)
                n_sums++;
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        action     = '0;
        first_pos  = '0;
        last_pos   = '0;
        out_ready  = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        burst_left = 0;
        gap_left   = 0;
        stall_mode = 0;
        stall_cnt  = 0;
        n_errors   = 0;
        n_checked  = 0;
        n_sums     = 0;
        size_reg   = RESET_SIZE;
        run_lo[0]  = pos_t'(1);
        run_hi[0]  = RESET_SIZE;
        run_total  = 1;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset table, swapped ends, edges, out of range, no-op.
        push_cmd(ACT_SUM, 1, 1024);
        push_cmd(ACT_INVERT, 1024, 1);
        push_cmd(ACT_SUM, 1, 1);
        push_cmd(ACT_INVERT, 10, 20);
        push_cmd(ACT_SUM, 15, 5);
        push_cmd(ACT_INVERT, 1, 1);
        push_cmd(ACT_SUM, 0, 5);
        push_cmd(ACT_SUM, 1, 1025);
        push_cmd(ACT_INVERT, 32'h3FFF_FFFF, 3);
        push_cmd(ACT_NOP, 32'h3FFF_FFFF, 32'h3FFF_FFFF);
        push_cmd(ACT_INIT, 32'h3FFF_FFFF, 0);
        push_cmd(ACT_SUM, 1024, 1024);
        drain();

        // Largest sequence: the sum reaches the top of its range.
        write_size(32'h3FFF_FFFF);
        push_cmd(ACT_INIT, 0, 0);
        push_cmd(ACT_SUM, 1, 32'h3FFF_FFFF);
        push_cmd(ACT_INVERT, 2, 32'h3FFF_FFFE);
        push_cmd(ACT_SUM, 32'h3FFF_FFFF, 1);
        push_cmd(ACT_SUM, 32'h2AAA_AAAA, 32'h1555_5555);
        random_phase(25);
        drain();

        // Empty sequence: every range is out of bounds.
        write_size(0);
        push_cmd(ACT_INIT, 0, 0);
        push_cmd(ACT_SUM, 1, 1);
        push_cmd(ACT_INVERT, 1, 1);
        drain();

        // One element, then small sizes where random ranges cut deep.
        write_size(1);
        push_cmd(ACT_INIT, 0, 0);
        push_cmd(ACT_INVERT, 1, 1);
        push_cmd(ACT_SUM, 1, 1);
        random_phase(10);
        write_size(48);
        push_cmd(ACT_INIT, 0, 0);
        random_phase(50);
        write_size($urandom_range(100, 5000));
        push_cmd(ACT_INIT, 0, 0);
        random_phase(45);
        drain();

        repeat (200) @(negedge clk);
        $display("Covered %0d checked results, %0d sum transactions, sizes 0..2^30-1.",
                 n_checked, n_sums);
        if (n_errors == 0 && result_q.size() == 0)
            $display("PASS range_reverse_sum_segments");
        else
            $display("FAIL range_reverse_sum_segments");
        $finish;
    end

endmodule

>>> range_reverse_sum_segments.f
hdl/rrss_pkg.sv
hdl/rrss_dp.sv
hdl/rrss_ctrl.sv
hdl/range_reverse_sum_segments.sv
hdl/rrss_chk.sv
tb/tb_top.sv
